/* rtl/lspp_pkg.sv */
// Shared types and constants of the line segment projector.
package lspp_pkg;

  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_XA   = 3'd0,
    REG_XB   = 3'd1,
    REG_YA   = 3'd2,
    REG_YB   = 3'd3,
    REG_WA   = 3'd4,
    REG_WB   = 3'd5,
    REG_ORG  = 3'd6,
    REG_SIZE = 3'd7
  } reg_idx_t;

  // Clip values: three 32x32 products floored by FRAC_BITS plus a 32-bit term,
  // wide enough for FRAC_BITS down to 8.
  localparam int unsigned CLIP_W = 57;
  // Numerator of a mapping: sum or difference of two clip values.
  localparam int unsigned NUM_W = CLIP_W + 1;
  // Divisor 2w.
  localparam int unsigned DEN_W = CLIP_W + 1;
  // Quotient: 33 integer bits (clamped to 2^32) plus fraction.
  localparam int unsigned QI_W = 33;

  localparam int unsigned TDATA_IN_W = 224;
  localparam int unsigned TDATA_OUT_W = 168;

  typedef struct packed {
    logic [31:0] colour;
    logic        last;
  } side_t;

endpackage

/* rtl/lspp_lane.sv */
// One endpoint lane: clip transform, pipelined restoring divide and viewport map.
module lspp_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [31:0]          px,
  input  logic signed [31:0]          py,
  input  logic signed [31:0]          pz,
  input  logic [63:0]                 xa,
  input  logic [63:0]                 xb,
  input  logic [63:0]                 ya,
  input  logic [63:0]                 yb,
  input  logic [63:0]                 wa,
  input  logic [63:0]                 wb,
  input  logic [63:0]                 org,
  input  logic [63:0]                 size,
  output logic                        vis,
  output logic signed [31:0]          sx,
  output logic signed [31:0]          sy
);

  localparam int unsigned CW = lspp_pkg::CLIP_W;
  localparam int unsigned NW = lspp_pkg::NUM_W;
  localparam int unsigned DW = lspp_pkg::DEN_W;
  localparam int unsigned QW = lspp_pkg::QI_W + FRAC_BITS;
  // integer part bits beyond those needed: numerator magnitude up to NW bits
  localparam int unsigned IB = NW;
  localparam int unsigned STEPS = IB + FRAC_BITS;
  localparam int unsigned RW = DW + 1;

  // stage 1: nine products
  logic signed [63:0] prod_r [9];
  logic signed [31:0] off_r [3];

  function automatic logic signed [CW-1:0] fl(input logic signed [63:0] v);
    logic signed [63:0] s;
    begin
      s = v >>> FRAC_BITS;
      fl = s[CW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r[0] <= px * $signed(xa[31:0]);
      prod_r[1] <= py * $signed(xa[63:32]);
      prod_r[2] <= pz * $signed(xb[31:0]);
      prod_r[3] <= px * $signed(ya[31:0]);
      prod_r[4] <= py * $signed(ya[63:32]);
      prod_r[5] <= pz * $signed(yb[31:0]);
      prod_r[6] <= px * $signed(wa[31:0]);
      prod_r[7] <= py * $signed(wa[63:32]);
      prod_r[8] <= pz * $signed(wb[31:0]);
      off_r[0]  <= $signed(xb[63:32]);
      off_r[1]  <= $signed(yb[63:32]);
      off_r[2]  <= $signed(wb[63:32]);
    end
  end

  // stage 2: clip values
  logic signed [CW-1:0] cx_r, cy_r, cw_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r <= fl(prod_r[0]) + fl(prod_r[1]) + fl(prod_r[2]) + CW'(off_r[0]);
      cy_r <= fl(prod_r[3]) + fl(prod_r[4]) + fl(prod_r[5]) + CW'(off_r[1]);
      cw_r <= fl(prod_r[6]) + fl(prod_r[7]) + fl(prod_r[8]) + CW'(off_r[2]);
    end
  end

  // divide pipeline: one quotient bit per stage for both axes
  logic [RW-1:0]    rx_r [STEPS+1];
  logic [RW-1:0]    ry_r [STEPS+1];
  logic [STEPS-1:0] qx_r [STEPS+1];
  logic [STEPS-1:0] qy_r [STEPS+1];
  logic [NW-1:0]    dnx_r [STEPS+1];
  logic [NW-1:0]    dny_r [STEPS+1];
  logic [DW-1:0]    dd_r [STEPS+1];
  logic             dsx_r [STEPS+1];
  logic             dsy_r [STEPS+1];
  logic             dv_r [STEPS+1];

  // stage 3: numerators, divisor
  logic signed [NW-1:0] nx, ny;
  always_comb begin
    nx = NW'(cx_r) + NW'(cw_r);
    ny = NW'(cw_r) - NW'(cy_r);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dsx_r[0] <= nx[NW-1];
      dsy_r[0] <= ny[NW-1];
      dnx_r[0] <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      dny_r[0] <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      dd_r[0]  <= {cw_r, 1'b0};
      dv_r[0]  <= (cw_r > 0);
      rx_r[0]  <= '0;
      ry_r[0]  <= '0;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_div
    logic [RW-1:0] tx, ty;
    logic          bx, by;
    always_comb begin
      bx = (g < IB) ? dnx_r[g][NW-1] : 1'b0;
      by = (g < IB) ? dny_r[g][NW-1] : 1'b0;
      tx = {rx_r[g][RW-2:0], bx};
      ty = {ry_r[g][RW-2:0], by};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[g+1]  <= (tx >= RW'(dd_r[g])) ? tx - RW'(dd_r[g]) : tx;
        ry_r[g+1]  <= (ty >= RW'(dd_r[g])) ? ty - RW'(dd_r[g]) : ty;
        qx_r[g+1]  <= {qx_r[g][STEPS-2:0], tx >= RW'(dd_r[g])};
        qy_r[g+1]  <= {qy_r[g][STEPS-2:0], ty >= RW'(dd_r[g])};
        dnx_r[g+1] <= {dnx_r[g][NW-2:0], 1'b0};
        dny_r[g+1] <= {dny_r[g][NW-2:0], 1'b0};
        dd_r[g+1]  <= dd_r[g];
        dsx_r[g+1] <= dsx_r[g];
        dsy_r[g+1] <= dsy_r[g];
        dv_r[g+1]  <= dv_r[g];
      end
    end
  end

  // clamp quotient to 2^32 integer part
  function automatic logic [QW-1:0] clampq(input logic [STEPS-1:0] q);
    logic [STEPS-FRAC_BITS-1:0] ip;
    begin
      ip = q[STEPS-1:FRAC_BITS];
      if (ip >= (STEPS-FRAC_BITS)'(64'h1_0000_0000))
        clampq = {1'b1, {(QW-1){1'b0}}};
      else
        clampq = QW'(q);
    end
  endfunction

  // multiply stage A: split Q (QI_W + FRAC_BITS bits, 49 by default) into low 24 and high part x |size| 32
  localparam int unsigned LOW_W = 24;
  localparam int unsigned HI_W = QW - LOW_W;
  logic [LOW_W+31:0] mlx_r, mly_r;
  logic [HI_W+31:0]  mhx_r, mhy_r;
  logic              mnx_r, mny_r, mv_r;
  logic signed [31:0] ox_r, oy_r;
  logic [QW-1:0]     qcx, qcy;
  logic [31:0]       asw, ash;
  logic signed [31:0] sw, sh;
  always_comb begin
    qcx = clampq(qx_r[STEPS]);
    qcy = clampq(qy_r[STEPS]);
    sw  = $signed(size[31:0]);
    sh  = $signed(size[63:32]);
    asw = sw[31] ? 32'(-sw) : 32'(sw);
    ash = sh[31] ? 32'(-sh) : 32'(sh);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      mlx_r <= qcx[LOW_W-1:0] * asw;
      mly_r <= qcy[LOW_W-1:0] * ash;
      mhx_r <= qcx[QW-1:LOW_W] * asw;
      mhy_r <= qcy[QW-1:LOW_W] * ash;
      mnx_r <= dsx_r[STEPS] ^ sw[31];
      mny_r <= dsy_r[STEPS] ^ sh[31];
      mv_r  <= dv_r[STEPS];
      ox_r  <= $signed(org[31:0]);
      oy_r  <= $signed(org[63:32]);
    end
  end

  // multiply stage B: combine, shift, sign, add origin, saturate
  localparam int unsigned MW = QW + 32;
  function automatic logic signed [31:0] fin(input logic [LOW_W+31:0] ml,
                                             input logic [HI_W+31:0] mh,
                                             input logic neg,
                                             input logic signed [31:0] o);
    logic [MW-1:0]       full;
    logic [MW-1:0]       mag;
    logic signed [MW+1:0] s;
    begin
      full = MW'(ml) + (MW'(mh) << LOW_W);
      mag  = full >> FRAC_BITS;
      if (mag > (MW'(1) << 34)) begin
        fin = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        s = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        s = s + (MW+2)'(o);
        if (s > (MW+2)'(64'sh7fff_ffff)) fin = 32'sh7fff_ffff;
        else if (s < -(MW+2)'(64'sh8000_0000)) fin = 32'sh8000_0000;
        else fin = s[31:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      vis <= mv_r;
      sx  <= mv_r ? fin(mlx_r, mhx_r, mnx_r, ox_r) : '0;
      sy  <= mv_r ? fin(mly_r, mhy_r, mny_r, oy_r) : '0;
    end
  end

endmodule

/* rtl/lspp_merge.sv */
// Merge stage: combine endpoint lanes into one result word.
module lspp_merge (
  input  logic               vis_a,
  input  logic               vis_b,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  lspp_pkg::side_t    side,
  output logic [lspp_pkg::TDATA_OUT_W-1:0] tdata,
  output logic               tlast
);
  logic v;
  always_comb begin
    v     = vis_a & vis_b;
    tdata = {7'd0, side.colour, v ? by : 32'd0, v ? bx : 32'd0,
             v ? ay : 32'd0, v ? ax : 32'd0, v};
    tlast = side.last;
  end
endmodule

/* rtl/line_segment_perspective_projector.sv */
// Top level of the line segment perspective projector.
// Throughput: one segment per cycle while not stalled; the divide is a fully pipelined restoring array.
// The whole pipeline stalls when the output register is full and not taken.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// matrix and viewport.
module line_segment_perspective_projector #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, line_colour
  input  logic [223:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // visible, screen_start_x, screen_start_y, screen_end_x, screen_end_y,
  // out_colour, zero fill
  output logic [167:0] out_tdata,
  output logic         out_tlast
);

  localparam int unsigned DEPTH = FRAC_BITS + lspp_pkg::NUM_W + 5;

  logic [63:0] regs_r [lspp_pkg::NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[lspp_pkg::REG_XA]   <= 64'(1) << FRAC_BITS;
      regs_r[lspp_pkg::REG_XB]   <= '0;
      regs_r[lspp_pkg::REG_YA]   <= 64'(1) << (FRAC_BITS + 32);
      regs_r[lspp_pkg::REG_YB]   <= '0;
      regs_r[lspp_pkg::REG_WA]   <= '0;
      regs_r[lspp_pkg::REG_WB]   <= 64'(1) << (FRAC_BITS + 32);
      regs_r[lspp_pkg::REG_ORG]  <= '0;
      regs_r[lspp_pkg::REG_SIZE] <= (64'd480 << (FRAC_BITS + 32)) | (64'd640 << FRAC_BITS);
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  logic adv;
  logic [DEPTH-1:0] vld_r;
  lspp_pkg::side_t side_r [DEPTH];

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= '{colour: in_tdata[223:192], last: in_tlast};
      for (int i = 1; i < DEPTH; i++) side_r[i] <= side_r[i-1];
    end
  end

  logic va, vb;
  logic signed [31:0] ax, ay, bx, by;

  lspp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
    .clk, .adv,
    .px($signed(in_tdata[31:0])), .py($signed(in_tdata[63:32])),
    .pz($signed(in_tdata[95:64])),
    .xa(regs_r[lspp_pkg::REG_XA]), .xb(regs_r[lspp_pkg::REG_XB]),
    .ya(regs_r[lspp_pkg::REG_YA]), .yb(regs_r[lspp_pkg::REG_YB]),
    .wa(regs_r[lspp_pkg::REG_WA]), .wb(regs_r[lspp_pkg::REG_WB]),
    .org(regs_r[lspp_pkg::REG_ORG]), .size(regs_r[lspp_pkg::REG_SIZE]),
    .vis(va), .sx(ax), .sy(ay)
  );

  lspp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk, .adv,
    .px($signed(in_tdata[127:96])), .py($signed(in_tdata[159:128])),
    .pz($signed(in_tdata[191:160])),
    .xa(regs_r[lspp_pkg::REG_XA]), .xb(regs_r[lspp_pkg::REG_XB]),
    .ya(regs_r[lspp_pkg::REG_YA]), .yb(regs_r[lspp_pkg::REG_YB]),
    .wa(regs_r[lspp_pkg::REG_WA]), .wb(regs_r[lspp_pkg::REG_WB]),
    .org(regs_r[lspp_pkg::REG_ORG]), .size(regs_r[lspp_pkg::REG_SIZE]),
    .vis(vb), .sx(bx), .sy(by)
  );

  lspp_merge u_merge (
    .vis_a(va), .vis_b(vb), .ax, .ay, .bx, .by,
    .side(side_r[DEPTH-1]), .tdata(out_tdata), .tlast(out_tlast)
  );

  assign out_tvalid = vld_r[DEPTH-1];

endmodule

/* rtl/lspp_checker.sv */
// Port-level checks of the projector, bound to the top level.
module lspp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [167:0] out_tdata,
  input logic         out_tlast
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[128:1] == '0)
    else $error("invisible segment has coordinates");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[167:161] == '0)
    else $error("fill bits set");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind line_segment_perspective_projector lspp_checker u_lspp_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast
);
